FILE: design/onr_pkg.sv
`timescale 1ns / 1ps
package onr_pkg;

	// Divisor width: max(cosI, cosO) stays below 2^17 for 16-bit inputs
	localparam int DEN_W = 17;
	// Partial remainder is always below the divisor, one extra bit for the shift
	localparam int REM_W = DEN_W + 1;
	// Positive numerator magnitude fits in this many bits
	localparam int NUM_W = 35;
	// Input component width
	localparam int CMP_W = 16;

	// Register indexes on the configuration port
	localparam logic REG_COEF_A = 1'b0;
	localparam logic REG_COEF_B = 1'b1;

	// Control that travels with an item down the pipeline
	typedef struct packed {
		logic vld;
		logic den_bad;
	} flags_t;

endpackage

FILE: design/oren_nayar_diffuse_factor.sv
`timescale 1ns / 1ps
// Qualitative Oren-Nayar diffuse factor A + B*max(0, wi.wo - cosI*cosO)/max(cosI, cosO),
// result unsigned Q3.13 with a saturation flag. Fully pipelined: one item per clock,
// through 3 setup stages, a row of FRAC_BITS + 20 divider cells giving one quotient
// bit each, a B multiply stage and the output register. The whole pipeline holds
// while a result waits on m_tready. coef_a and coef_b are used as written; change
// them only while the block is empty.
module oren_nayar_diffuse_factor #(
	parameter int FRAC_BITS = 15
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// wi_x, wi_y, wi_z, wo_x, wo_y, wo_z, normal_x, normal_y, normal_z
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// factor [15:0], saturated [16], zero fill [23:17]
	output logic [23:0]  m_tdata
);

	localparam int DW = FRAC_BITS + 20;
	localparam int TW = FRAC_BITS + 18;
	localparam int MW = 14 + TW;

	logic        en;
	logic [15:0] coef_a_q;
	logic [13:0] coef_b_q;

	onr_pkg::flags_t           flg [DW+1];
	logic [onr_pkg::DEN_W-1:0] den [DW+1];
	logic [onr_pkg::REM_W-1:0] rem [DW+1];
	logic [DW-1:0]             nq  [DW+1];

	onr_pkg::flags_t flg_m1;
	logic            big_m1;
	logic [MW-1:0]   prod_m1;
	logic [MW-FRAC_BITS-3:0] bpart;
	logic [MW-FRAC_BITS-2:0] sum;
	logic [15:0]     factor_q;
	logic            sat_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata  = {7'b0, sat_q, factor_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= 16'd32768;
			coef_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				onr_pkg::REG_COEF_A: coef_a_q <= cfg_data;
				onr_pkg::REG_COEF_B: coef_b_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	onr_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(s_tvalid), .in_data(s_tdata),
		.flg(flg[0]), .den(den[0]), .dvd(nq[0])
	);
	assign rem[0] = '0;

	// divider row
	for (genvar g = 0; g < DW; g++) begin : g_cell
		onr_div_cell #(.DW(DW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.flg_in(flg[g]), .den_in(den[g]), .rem_in(rem[g]), .nq_in(nq[g]),
			.flg_out(flg[g+1]), .den_out(den[g+1]), .rem_out(rem[g+1]),
			.nq_out(nq[g+1])
		);
	end

	// B times the ratio; a ratio at or above 2^(FRAC_BITS+18) overflows any nonzero B
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_m1 <= '0;
		end else if (en) begin
			flg_m1 <= flg[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_m1  <= (nq[DW][DW-1:TW] != '0) && (coef_b_q != '0);
			prod_m1 <= MW'(coef_b_q) * MW'(nq[DW][TW-1:0]);
		end
	end

	// final sum and clipping
	always_comb begin
		bpart = prod_m1[MW-1:FRAC_BITS+2];
		sum   = (MW-FRAC_BITS-1)'(coef_a_q[15:2]) + (MW-FRAC_BITS-1)'(bpart);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= flg_m1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_m1.den_bad || big_m1 || (sum > (MW-FRAC_BITS-1)'(65535))) begin
				factor_q <= 16'hFFFF;
				sat_q    <= 1'b1;
			end else begin
				factor_q <= sum[15:0];
				sat_q    <= 1'b0;
			end
		end
	end

endmodule

FILE: design/onr_front.sv
`timescale 1ns / 1ps
// Dot products, cosine rounding and numerator / divisor setup, three stages.
module onr_front #(
	parameter int FRAC_BITS = 15,
	parameter int DW = FRAC_BITS + 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [9*onr_pkg::CMP_W-1:0] in_data,
	output onr_pkg::flags_t             flg,
	output logic [onr_pkg::DEN_W-1:0]   den,
	output logic [DW-1:0]               dvd
);

	localparam int PW = 2 * onr_pkg::CMP_W;
	localparam int SHR = 45 - FRAC_BITS;

	logic signed [onr_pkg::CMP_W-1:0] cmp [9];
	logic signed [PW-1:0] pr_in [3];
	logic signed [PW-1:0] pr_on [3];
	logic signed [PW-1:0] pr_io [3];
	logic signed [PW+1:0] dot_in, dot_on, dot_io;
	logic signed [PW+2:0] bias_in, bias_on;
	logic signed [19:0] cos_i, cos_o, den_w;
	logic signed [39:0] cprod;
	logic signed [40:0] num;

	logic                 vld_s1, vld_s2;
	logic signed [PW-1:0] pin_s1 [3];
	logic signed [PW-1:0] pon_s1 [3];
	logic signed [PW-1:0] pio_s1 [3];
	logic signed [PW+1:0] dio_s2;
	logic signed [39:0]   cprod_s2;
	logic signed [19:0]   den_s2;
	logic [64:0]          wide;

	// unpack components: wi 0..2, wo 3..5, normal 6..8
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			cmp[k] = in_data[k*onr_pkg::CMP_W +: onr_pkg::CMP_W];
		end
		for (int k = 0; k < 3; k++) begin
			pr_in[k] = cmp[k] * cmp[6+k];
			pr_on[k] = cmp[3+k] * cmp[6+k];
			pr_io[k] = cmp[k] * cmp[3+k];
		end
	end

	// stage 1: nine products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pin_s1 <= pr_in;
			pon_s1 <= pr_on;
			pio_s1 <= pr_io;
		end
	end

	// sums and rounding to Q.15, ties toward plus infinity
	always_comb begin
		dot_in  = (PW+2)'(pin_s1[0]) + (PW+2)'(pin_s1[1]) + (PW+2)'(pin_s1[2]);
		dot_on  = (PW+2)'(pon_s1[0]) + (PW+2)'(pon_s1[1]) + (PW+2)'(pon_s1[2]);
		dot_io  = (PW+2)'(pio_s1[0]) + (PW+2)'(pio_s1[1]) + (PW+2)'(pio_s1[2]);
		bias_in = (PW+3)'(dot_in) + (PW+3)'(16384);
		bias_on = (PW+3)'(dot_on) + (PW+3)'(16384);
		cos_i   = 20'(bias_in >>> 15);
		cos_o   = 20'(bias_on >>> 15);
		den_w   = (cos_i > cos_o) ? cos_i : cos_o;
		cprod   = cos_i * cos_o;
	end

	// stage 2: wi.wo dot product, cosine product, divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dio_s2   <= dot_io;
			cprod_s2 <= cprod;
			den_s2   <= den_w;
		end
	end

	// numerator, scaled to FRAC_BITS fraction bits of the ratio
	always_comb begin
		num  = 41'(dio_s2) - 41'(cprod_s2);
		wide = {num[onr_pkg::NUM_W-1:0], 30'b0} >> SHR;
	end

	// stage 3: divider operands; non-positive numerator or bad divisor divides as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg <= '0;
		end else if (en) begin
			flg.vld     <= vld_s2;
			flg.den_bad <= den_s2[19] || (den_s2 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den <= den_s2[onr_pkg::DEN_W-1:0];
			if (num[40] || (num == '0) || den_s2[19] || (den_s2 == '0)) begin
				dvd <= '0;
			end else begin
				dvd <= wide[DW-1:0];
			end
		end
	end

endmodule

FILE: design/onr_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division step: one quotient bit per cell.
module onr_div_cell #(
	parameter int DW = 35
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  onr_pkg::flags_t           flg_in,
	input  logic [onr_pkg::DEN_W-1:0] den_in,
	input  logic [onr_pkg::REM_W-1:0] rem_in,
	input  logic [DW-1:0]             nq_in,
	output onr_pkg::flags_t           flg_out,
	output logic [onr_pkg::DEN_W-1:0] den_out,
	output logic [onr_pkg::REM_W-1:0] rem_out,
	output logic [DW-1:0]             nq_out
);

	logic [onr_pkg::REM_W:0] shl;
	logic                    ge;

	// bring down the next dividend bit and try the subtract
	always_comb begin
		shl = {rem_in, nq_in[DW-1]};
		ge  = shl >= (onr_pkg::REM_W+1)'(den_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_out <= '0;
		end else if (en) begin
			flg_out <= flg_in;
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			den_out <= den_in;
			rem_out <= ge ? onr_pkg::REM_W'(shl - (onr_pkg::REM_W+1)'(den_in))
			              : onr_pkg::REM_W'(shl);
			nq_out  <= {nq_in[DW-2:0], ge};
		end
	end

endmodule

FILE: bench/oren_nayar_diffuse_factor_tb.sv
`timescale 1ns / 1ps
module oren_nayar_diffuse_factor_tb;

	localparam int FRAC_BITS = 15;
	localparam int LATENCY = FRAC_BITS + 25;
	localparam int WATCHDOG_LIMIT = 20000;

	// saturated sits above factor, as on m_tdata
	typedef struct packed {
		logic        saturated;
		logic [15:0] factor;
	} diffuse_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [15:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;

	oren_nayar_diffuse_factor #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor copy of the registers
	logic [15:0] model_a;
	logic [13:0] model_b;

	logic [143:0] vec_queue[$];
	diffuse_t     factor_queue[$];
	int  mismatches;
	int  sent_count;
	int  recv_hold;
	bit  timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor((d + 2^14) / 2^15)
	function automatic longint round_cos(longint d);
		return (d + 16384) >>> 15;
	endfunction

	function automatic diffuse_t predict_factor(logic [143:0] v, logic [15:0] ca,
			logic [13:0] cb);
		longint c[9];
		longint dot_in, dot_on, dot_io, cos_i, cos_o, den, num;
		logic [63:0] t, a_part, b_part, sum;
		diffuse_t r;
		bit sat;
		for (int k = 0; k < 9; k++)
			c[k] = longint'($signed(v[k*16 +: 16]));
		dot_in = c[0]*c[6] + c[1]*c[7] + c[2]*c[8];
		dot_on = c[3]*c[6] + c[4]*c[7] + c[5]*c[8];
		dot_io = c[0]*c[3] + c[1]*c[4] + c[2]*c[5];
		cos_i = round_cos(dot_in);
		cos_o = round_cos(dot_on);
		den = (cos_i > cos_o) ? cos_i : cos_o;
		num = dot_io - cos_i * cos_o;
		a_part = 64'(ca) >> 2;
		b_part = 0;
		sat = 1'b0;
		if (den <= 0) begin
			sat = 1'b1;
		end else if (num > 0 && cb != 0) begin
			t = (64'(num) << FRAC_BITS) / (64'(den) << 15);
			if (t > (64'd1 << 50))
				sat = 1'b1;
			else
				b_part = (64'(cb) * t) >> (FRAC_BITS + 2);
		end
		sum = 64'd65535;
		if (!sat) begin
			sum = a_part + b_part;
			if (sum > 64'd65535) begin
				sum = 64'd65535;
				sat = 1'b1;
			end
		end
		r.factor = sum[15:0];
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [143:0] pack_vec(int v[9]);
		logic [143:0] d;
		for (int k = 0; k < 9; k++)
			d[k*16 +: 16] = 16'(v[k]);
		return d;
	endfunction

	function automatic int rnd_comp();
		return int'($signed(16'($urandom)));
	endfunction

	// unit-ish vector near a random direction, z-heavy for the upper hemisphere
	function automatic void rnd_unit(output int x, output int y, output int z);
		real a, b, nrm, fx, fy, fz;
		a = ($urandom_range(0, 62831)) / 10000.0;
		b = ($urandom_range(0, 15707)) / 10000.0;
		fx = $cos(a) * $sin(b);
		fy = $sin(a) * $sin(b);
		fz = $cos(b);
		nrm = 32767.0;
		x = int'(fx * nrm);
		y = int'(fy * nrm);
		z = int'(fz * nrm);
	endfunction

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == onr_pkg::REG_COEF_A)
			model_a = val;
		else
			model_b = val[13:0];
	endtask

	task automatic wait_drained();
		while ((vec_queue.size() != 0 || factor_queue.size() != 0) && !timed_out)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic add_random(int count);
		int v[9];
		int x, y, z;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				rnd_unit(x, y, z); v[0] = x; v[1] = y; v[2] = z;
				rnd_unit(x, y, z); v[3] = x; v[4] = y; v[5] = z;
				v[6] = 0; v[7] = 0; v[8] = 32767;
				if ($urandom_range(0, 3) == 0) begin
					rnd_unit(x, y, z); v[6] = x; v[7] = y; v[8] = z;
				end
			end else begin
				for (int k = 0; k < 9; k++)
					v[k] = rnd_comp();
			end
			vec_queue.push_back(pack_vec(v));
		end
	endtask

	// driver: random gap after each accepted item, ports driven with nonblocking writes
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				factor_queue.push_back(predict_factor(s_tdata, model_a, model_b));
				void'(vec_queue.pop_front());
				sent_count++;
				send_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered item
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (vec_queue.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= vec_queue[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compares each transfer with the oldest prediction
	int  recv_gap;
	int  idle_cycles;
	always @(posedge clk or negedge arst_n) begin
		diffuse_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
			idle_cycles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = diffuse_t'(m_tdata[16:0]);
				if (factor_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer factor=%0d sat=%0d",
							got.factor, got.saturated);
				end else begin
					want = factor_queue.pop_front();
					if (got.factor !== want.factor || got.saturated !== want.saturated
							|| m_tdata[23:17] !== 7'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected factor=%0d sat=%0d, got factor=%0d sat=%0d",
								want.factor, want.saturated, got.factor, got.saturated);
					end
				end
				recv_gap = $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0) recv_gap = 0;
			end
			// cycles with no transfer on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int v[9];
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		mismatches = 0; sent_count = 0; recv_hold = 0; timed_out = 1'b0;
		model_a = 16'd32768; model_b = 14'd0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers first
		v = '{0, 0, 32767, 0, 0, 32767, 0, 0, 32767};
		vec_queue.push_back(pack_vec(v));
		wait_drained();
		write_reg(onr_pkg::REG_COEF_A, 16'd26000);
		write_reg(onr_pkg::REG_COEF_B, 16'd14746);
		// grazing-ish in/out, opposite azimuth (cosine term negative)
		v = '{32767, 0, 0, -32767, 0, 0, 0, 0, 32767};     vec_queue.push_back(pack_vec(v));
		// divisor not positive
		v = '{0, 0, -32768, 0, 0, -32768, 0, 0, 32767};    vec_queue.push_back(pack_vec(v));
		v = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};      vec_queue.push_back(pack_vec(v));
		// same azimuth, both near grazing: huge ratio
		v = '{32767, 0, 1, 32767, 0, 1, 0, 0, 32767};      vec_queue.push_back(pack_vec(v));
		v = '{30000, 0, 13000, 20000, 0, 26000, 0, 0, 32767}; vec_queue.push_back(pack_vec(v));
		v = '{23170, 0, 23170, 23170, 0, 23170, 0, 0, 32767}; vec_queue.push_back(pack_vec(v));
		// all extremes, non-unit
		v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
		vec_queue.push_back(pack_vec(v));
		v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
		vec_queue.push_back(pack_vec(v));
		v = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
		vec_queue.push_back(pack_vec(v));
		v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  vec_queue.push_back(pack_vec(v));
		v = '{30000, 100, 13000, 30000, -100, 13000, 0, 0, 32767}; vec_queue.push_back(pack_vec(v));
		wait_drained();
		// factor overflow: A at the top of its width
		write_reg(onr_pkg::REG_COEF_A, 16'hFFFF);
		write_reg(onr_pkg::REG_COEF_B, 16'h3FFF);
		v = '{30000, 0, 13000, 20000, 0, 26000, 0, 0, 32767}; vec_queue.push_back(pack_vec(v));
		v = '{0, 0, 32767, 0, 0, 32767, 0, 0, 32767};      vec_queue.push_back(pack_vec(v));
		add_random(150);
		wait_drained();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(onr_pkg::REG_COEF_A, 16'd0);
					write_reg(onr_pkg::REG_COEF_B, 16'd0);
				end
				1: begin
					write_reg(onr_pkg::REG_COEF_A, 16'd32768);
					write_reg(onr_pkg::REG_COEF_B, 16'd14746);
				end
				2: begin
					write_reg(onr_pkg::REG_COEF_A, 16'($urandom_range(0, 32768)));
					write_reg(onr_pkg::REG_COEF_B, 16'($urandom_range(0, 14746)));
				end
				3: begin
					write_reg(onr_pkg::REG_COEF_A, 16'($urandom));
					write_reg(onr_pkg::REG_COEF_B, 16'($urandom));
				end
				4: begin
					write_reg(onr_pkg::REG_COEF_A, 16'd32768);
					write_reg(onr_pkg::REG_COEF_B, 16'd1);
				end
				default: begin
					write_reg(onr_pkg::REG_COEF_A, 16'($urandom_range(0, 32768)));
					write_reg(onr_pkg::REG_COEF_B, 16'($urandom_range(0, 14746)));
				end
			endcase
			if (ph == 1) recv_hold = 300;
			add_random(190);
			wait_drained();
		end

		if (timed_out) begin
			$display("simulation failed");
		end else if (mismatches == 0 && factor_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog exit
	initial begin
		wait (timed_out);
		$display("simulation failed");
		$finish;
	end

endmodule
